[sv/tlc_pkg.sv]
// Shared types, codes and defaults for the tile light culler.
`default_nettype none

package tlc_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PER_TILE_DEFAULT     = 1024;
   localparam int INDEX_LIST_DEPTH_DEFAULT = 16384;

   // Largest count the 11-bit kept counter can hold
   localparam int COUNT_LIMIT = 2047;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 31;
   localparam int LIGHT_W  = 16;
   localparam int OFFSET_W = 20;
   localparam int COUNT_W  = 11;
   localparam int PLANE_W  = 48;
   localparam int NORMAL_W = 16;
   localparam int PROD_W   = NORMAL_W + COORD_W;
   localparam int DIST_W   = PROD_W + 2;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_LIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;

   // Control register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_TOP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
   localparam int NUM_PLANES = 4;
   localparam int NUM_AXES   = 3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Work handed from front to back
   typedef enum logic [1:0] {
      OP_KEEP,
      OP_CLOSE,
      OP_FRAME
   } tlc_op_type;

   typedef struct packed {
      tlc_op_type         op;
      logic [LIGHT_W-1:0] light_number;
   } tlc_entry_type;

endpackage

`default_nettype wire

[sv/tlc_front.sv]
// Front end: plane registers, plane tests and classification of each request beat.
`default_nettype none

module tlc_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tlc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tlc_pkg::PLANE_W-1:0]          csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tlc_pkg::KIND_W-1:0]           req_kind,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_z,
   input  wire logic [tlc_pkg::RADIUS_W-1:0]         req_radius,
   input  wire logic [tlc_pkg::LIGHT_W-1:0]          req_light_number,
   input  wire logic                                 pop,
   output logic                                      push,
   output tlc_pkg::tlc_entry_type                    push_entry
);

   logic [tlc_pkg::PLANE_W-1:0]                plane_ff [tlc_pkg::NUM_PLANES];
   logic signed [tlc_pkg::COORD_W-1:0]         center [tlc_pkg::NUM_AXES];
   logic signed [tlc_pkg::PROD_W-1:0]          prod_in [tlc_pkg::NUM_PLANES][tlc_pkg::NUM_AXES];
   logic signed [tlc_pkg::PROD_W-1:0]          prod_ff [tlc_pkg::NUM_PLANES][tlc_pkg::NUM_AXES];
   logic                                       p_valid_ff;
   logic [tlc_pkg::KIND_W-1:0]                 p_kind_ff;
   logic [tlc_pkg::RADIUS_W-1:0]               p_radius_ff;
   logic [tlc_pkg::LIGHT_W-1:0]                p_light_ff;
   logic signed [tlc_pkg::DIST_W-1:0]          plane_dist [tlc_pkg::NUM_PLANES];
   logic signed [tlc_pkg::DIST_W-1:0]          radius_q31;
   logic                                       pass_all;
   logic                                       drop;
   logic                                       accept;
   logic [tlc_pkg::QCOUNT_W-1:0]               occ_ff;
   logic [tlc_pkg::QCOUNT_W-1:0]               occ_in;

   // Plane registers; writes past the last plane are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlc_pkg::NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_write_enable &&
                   csr_index <= tlc_pkg::REG_PLANE_BOTTOM) begin
         plane_ff[csr_index[1:0]] <= csr_write_data;
      end
   end

   // Credit check: stage plus queue never hold more than the queue depth
   assign req_ready = occ_ff < tlc_pkg::QCOUNT_W'(tlc_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign center[0] = req_center_x;
   assign center[1] = req_center_y;
   assign center[2] = req_center_z;

   // Twelve Q1.15 x Q16.16 products, exact in Q17.31
   always_comb begin
      for (int i = 0; i < tlc_pkg::NUM_PLANES; i++) begin
         for (int j = 0; j < tlc_pkg::NUM_AXES; j++) begin
            prod_in[i][j] = $signed(plane_ff[i][tlc_pkg::NORMAL_W*j +: tlc_pkg::NORMAL_W])
                            * center[j];
         end
      end
   end

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
      end
      if (accept) begin
         prod_ff     <= prod_in;
         p_kind_ff   <= req_kind;
         p_radius_ff <= req_radius;
         p_light_ff  <= req_light_number;
      end
   end

   // Plane distances and radius compare
   assign radius_q31 = $signed({4'b0, p_radius_ff, 15'b0});

   always_comb begin
      pass_all = 1'b1;
      for (int i = 0; i < tlc_pkg::NUM_PLANES; i++) begin
         plane_dist[i] = {{2{prod_ff[i][0][tlc_pkg::PROD_W-1]}}, prod_ff[i][0]}
                       + {{2{prod_ff[i][1][tlc_pkg::PROD_W-1]}}, prod_ff[i][1]}
                       + {{2{prod_ff[i][2][tlc_pkg::PROD_W-1]}}, prod_ff[i][2]};
         if (!(plane_dist[i] < radius_q31)) begin
            pass_all = 1'b0;
         end
      end
   end

   // Classify; failing lights and unused kinds go no further
   always_comb begin
      push_entry.light_number = p_light_ff;
      push_entry.op           = tlc_pkg::OP_KEEP;
      drop                    = 1'b0;
      case (p_kind_ff)
         tlc_pkg::KIND_LIGHT: begin
            push_entry.op = tlc_pkg::OP_KEEP;
            drop          = !pass_all;
         end
         tlc_pkg::KIND_CLOSE: begin
            push_entry.op = tlc_pkg::OP_CLOSE;
         end
         tlc_pkg::KIND_FRAME: begin
            push_entry.op = tlc_pkg::OP_FRAME;
         end
         default: begin
            drop = 1'b1;
         end
      endcase
      drop = drop && p_valid_ff;
   end

   assign push = p_valid_ff && !drop;

   // Items held between acceptance and pop
   assign occ_in = occ_ff + tlc_pkg::QCOUNT_W'(accept)
                 - tlc_pkg::QCOUNT_W'(drop) - tlc_pkg::QCOUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Credit count stays within the queue depth
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= tlc_pkg::QCOUNT_W'(tlc_pkg::QUEUE_DEPTH))
      else $error("front credit count above queue depth");

endmodule

`default_nettype wire

[sv/tlc_queue.sv]
// Short queue of classified work between front and back.
`default_nettype none

module tlc_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire tlc_pkg::tlc_entry_type   push_entry,
   input  wire logic                     pop,
   output logic                          pop_valid,
   output tlc_pkg::tlc_entry_type        pop_entry
);

   tlc_pkg::tlc_entry_type           mem_ff [tlc_pkg::QUEUE_DEPTH];
   logic [tlc_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [tlc_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [tlc_pkg::QCOUNT_W-1:0]     count_ff;
   logic [tlc_pkg::QCOUNT_W-1:0]     count_in;

   assign pop_valid = count_ff != '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign count_in = count_ff + tlc_pkg::QCOUNT_W'(push) - tlc_pkg::QCOUNT_W'(pop);

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Credits in the front keep the queue from overrunning
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < tlc_pkg::QCOUNT_W'(tlc_pkg::QUEUE_DEPTH)) || pop)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

[sv/tlc_back.sv]
// Back end: per-tile count, running offset and the result register.
`default_nettype none

module tlc_back #(
   parameter int MAX_PER_TILE     = tlc_pkg::MAX_PER_TILE_DEFAULT,
   parameter int INDEX_LIST_DEPTH = tlc_pkg::INDEX_LIST_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_valid,
   input  wire tlc_pkg::tlc_entry_type           q_entry,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_is_summary,
   output logic [tlc_pkg::LIGHT_W-1:0]           rsp_passed_light,
   output logic [tlc_pkg::OFFSET_W-1:0]          rsp_slot_or_offset,
   output logic [tlc_pkg::COUNT_W-1:0]           rsp_tile_total,
   output logic                                  rsp_list_overflow
);

   localparam logic [tlc_pkg::COUNT_W-1:0] TILE_CAP =
      tlc_pkg::COUNT_W'((MAX_PER_TILE > tlc_pkg::COUNT_LIMIT) ?
                        tlc_pkg::COUNT_LIMIT : MAX_PER_TILE);
   localparam logic [tlc_pkg::OFFSET_W:0] DEPTH_LIMIT =
      (tlc_pkg::OFFSET_W + 1)'(INDEX_LIST_DEPTH);

   logic [tlc_pkg::COUNT_W-1:0]   kept_ff, kept_in;
   logic [tlc_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic                          valid_ff, valid_in;
   logic                          summary_ff, summary_in;
   logic [tlc_pkg::LIGHT_W-1:0]   light_ff, light_in;
   logic [tlc_pkg::OFFSET_W-1:0]  slot_ff, slot_in;
   logic [tlc_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic                          overflow_ff, overflow_in;
   logic [tlc_pkg::OFFSET_W:0]    tile_end;

   // Take the next item whenever the result register is free or draining
   assign pop      = q_valid && (!valid_ff || rsp_ready);
   assign tile_end = {1'b0, offset_ff} + (tlc_pkg::OFFSET_W + 1)'(kept_ff);

   always_comb begin
      kept_in     = kept_ff;
      offset_in   = offset_ff;
      valid_in    = valid_ff && !rsp_ready;
      summary_in  = summary_ff;
      light_in    = light_ff;
      slot_in     = slot_ff;
      total_in    = total_ff;
      overflow_in = overflow_ff;
      if (pop) begin
         case (q_entry.op)
            tlc_pkg::OP_KEEP: begin
               if (kept_ff < TILE_CAP) begin
                  valid_in    = 1'b1;
                  summary_in  = 1'b0;
                  light_in    = q_entry.light_number;
                  slot_in     = offset_ff + tlc_pkg::OFFSET_W'(kept_ff);
                  total_in    = '0;
                  overflow_in = 1'b0;
                  kept_in     = kept_ff + 1'b1;
               end
            end
            tlc_pkg::OP_CLOSE: begin
               valid_in    = 1'b1;
               summary_in  = 1'b1;
               light_in    = '0;
               slot_in     = offset_ff;
               total_in    = kept_ff;
               overflow_in = tile_end > DEPTH_LIMIT;
               offset_in   = tile_end[tlc_pkg::OFFSET_W-1:0];
               kept_in     = '0;
            end
            tlc_pkg::OP_FRAME: begin
               offset_in = '0;
               kept_in   = '0;
            end
            default: begin
               kept_in = kept_ff;
            end
         endcase
      end
   end

   // Tile state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff   <= '0;
         offset_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         kept_ff   <= kept_in;
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
      summary_ff  <= summary_in;
      light_ff    <= light_in;
      slot_ff     <= slot_in;
      total_ff    <= total_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_is_summary     = summary_ff;
   assign rsp_passed_light   = light_ff;
   assign rsp_slot_or_offset = slot_ff;
   assign rsp_tile_total     = total_ff;
   assign rsp_list_overflow  = overflow_ff;

   // Count never passes the cap
   assert property (@(posedge clock) disable iff (reset)
      kept_ff <= TILE_CAP)
      else $error("kept count above tile cap");

   // Closing a tile restarts the count
   assert property (@(posedge clock) disable iff (reset)
      (pop && q_entry.op == tlc_pkg::OP_CLOSE) |=> kept_ff == '0)
      else $error("kept count not cleared after tile close");

endmodule

`default_nettype wire

[sv/tile_light_culler.sv]
// Top level of the tile light culler: front, work queue and back.
//
//   channel  direction  handshake                   beat
//   req      in         req_valid / req_ready       kind, centre, radius, light number
//   rsp      out        rsp_valid / rsp_ready       light record or tile summary
//   csr      in         csr_write_enable            plane register write, no wait
//
// One request beat per cycle while queue credit lasts; a passing light or a close
// gives its rsp beat through the product register, the queue and the result register.
// The front stalls only when the eight-entry queue credit runs out, which follows
// from rsp_ready held low; the back stalls only on rsp_ready.
// Reset is synchronous: it clears the planes, the count, the offset and the queue.
// Plane writes take effect in the next cycle.
`default_nettype none

module tile_light_culler #(
   parameter int MAX_PER_TILE     = tlc_pkg::MAX_PER_TILE_DEFAULT,
   parameter int INDEX_LIST_DEPTH = tlc_pkg::INDEX_LIST_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tlc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tlc_pkg::PLANE_W-1:0]          csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tlc_pkg::KIND_W-1:0]           req_kind,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_x,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_y,
   input  wire logic signed [tlc_pkg::COORD_W-1:0]   req_center_z,
   input  wire logic [tlc_pkg::RADIUS_W-1:0]         req_radius,
   input  wire logic [tlc_pkg::LIGHT_W-1:0]          req_light_number,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_is_summary,
   output logic [tlc_pkg::LIGHT_W-1:0]               rsp_passed_light,
   output logic [tlc_pkg::OFFSET_W-1:0]              rsp_slot_or_offset,
   output logic [tlc_pkg::COUNT_W-1:0]               rsp_tile_total,
   output logic                                      rsp_list_overflow
);

   logic                      push;
   logic                      pop;
   logic                      q_valid;
   tlc_pkg::tlc_entry_type    push_entry;
   tlc_pkg::tlc_entry_type    q_entry;

   // Plane tests and classification
   tlc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_radius       (req_radius),
      .req_light_number (req_light_number),
      .pop              (pop),
      .push             (push),
      .push_entry       (push_entry)
   );

   // Work queue
   tlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   // Tile bookkeeping and results
   tlc_back #(
      .MAX_PER_TILE     (MAX_PER_TILE),
      .INDEX_LIST_DEPTH (INDEX_LIST_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_entry            (q_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_summary     (rsp_is_summary),
      .rsp_passed_light   (rsp_passed_light),
      .rsp_slot_or_offset (rsp_slot_or_offset),
      .rsp_tile_total     (rsp_tile_total),
      .rsp_list_overflow  (rsp_list_overflow)
   );

endmodule

`default_nettype wire
